[rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros used by the checker module of the interval timer.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is applied.
`define ITC_ASSERT(lbl, clock, rstn, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define ITC_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) \
    else $error(msg);

`endif

[rtl/itc_pkg.sv]
// -----------------------------------------------------------------------------
// itc_pkg
// Types and constants shared by the two-channel interval timer files.
// -----------------------------------------------------------------------------
package itc_pkg;

  // Default width of the down counters.
  localparam int COUNTER_WIDTH = 16;

  // Kind of access carried by an input item.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2
  } item_mode_t;

  // Port addresses.
  typedef enum logic [1:0] {
    PORT_CH0  = 2'd0,
    PORT_CH2  = 2'd1,
    PORT_CMD  = 2'd2,
    PORT_GATE = 2'd3
  } port_sel_t;

  // Command byte fields.
  localparam logic [1:0] CMD_SEL_CH0     = 2'b00;
  localparam logic [1:0] CMD_SEL_CH2     = 2'b10;
  localparam logic [1:0] CMD_ACC_LATCH   = 2'b00;
  localparam logic [2:0] CMD_MODE_RATE   = 3'd2;
  localparam logic [2:0] CMD_MODE_RATE_X = 3'd6;

  // Bit of the gate port that shows the channel 2 output on a read.
  localparam int GATE_OUT_BIT = 5;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] port_sel;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       expiry_pulse;
    logic       ruler_output;
  } out_item_t;

endpackage

[rtl/interval_timer_two_channel_top.sv]
// -----------------------------------------------------------------------------
// Interval timer with two down counters, a stage-one and a result register.
// Throughput one item per cycle; stalls only when the result register is held.
// Reset (rst_n low, synchronous) clears counters, modes and pipeline valids.
// -----------------------------------------------------------------------------
module interval_timer_two_channel_top #(
  parameter int CounterWidth = itc_pkg::COUNTER_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  itc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output itc_pkg::out_item_t out_data
);

  // The block is a two-register pipeline. Stage one holds the accepted item;
  // the timer state and the result register are both updated from it in the
  // same cycle, so every item sees the state left by the item before it.

  logic               s1_valid_r;
  itc_pkg::in_item_t  s1_data_r;
  logic               out_valid_r;
  itc_pkg::out_item_t out_data_r;
  itc_pkg::out_item_t out_data_nxt;

  logic advance;
  logic fire;

  // Per channel state. Index 0 is channel 0, index 1 is channel 2.
  logic [CounterWidth-1:0] counter_value_r    [2];
  logic [CounterWidth-1:0] counter_value_nxt  [2];
  logic [CounterWidth-1:0] reload_value_r     [2];
  logic [CounterWidth-1:0] reload_value_nxt   [2];
  logic [CounterWidth-1:0] latched_value_r    [2];
  logic [CounterWidth-1:0] latched_value_nxt  [2];
  logic [7:0]              pending_low_r      [2];
  logic [7:0]              pending_low_nxt    [2];
  logic                    periodic_mode_r    [2];
  logic                    periodic_mode_nxt  [2];
  logic                    write_phase_r      [2];
  logic                    write_phase_nxt    [2];
  logic                    read_phase_r       [2];
  logic                    read_phase_nxt     [2];
  logic                    latch_held_r       [2];
  logic                    latch_held_nxt     [2];
  logic                    running_r          [2];
  logic                    running_nxt        [2];
  logic                    output_level_r     [2];
  logic                    output_level_nxt   [2];
  logic [1:0]              gate_bits_r;
  logic [1:0]              gate_bits_nxt;

  // The result register moves on when it is empty or being taken. Stage one
  // can take a new item whenever its own item moves into the result register
  // in the same cycle, giving a sustained one item per clock while results are taken.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Timer state. It only changes when an item completes its pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < 2; ch++) begin
        counter_value_r[ch] <= '0;
        reload_value_r[ch]  <= '0;
        latched_value_r[ch] <= '0;
        pending_low_r[ch]   <= '0;
        periodic_mode_r[ch] <= 1'b0;
        write_phase_r[ch]   <= 1'b0;
        read_phase_r[ch]    <= 1'b0;
        latch_held_r[ch]    <= 1'b0;
        running_r[ch]       <= 1'b0;
        output_level_r[ch]  <= 1'b0;
      end
      gate_bits_r <= '0;
    end else if (fire) begin
      counter_value_r <= counter_value_nxt;
      reload_value_r  <= reload_value_nxt;
      latched_value_r <= latched_value_nxt;
      pending_low_r   <= pending_low_nxt;
      periodic_mode_r <= periodic_mode_nxt;
      write_phase_r   <= write_phase_nxt;
      read_phase_r    <= read_phase_nxt;
      latch_held_r    <= latch_held_nxt;
      running_r       <= running_nxt;
      output_level_r  <= output_level_nxt;
      gate_bits_r     <= gate_bits_nxt;
    end
  end

  // Next state and result for the item in stage one. Each channel needs at
  // most one decrement and one compare against zero, so this is short logic.
  always_comb begin
    logic                    is_write;
    logic                    is_read;
    logic                    is_tick;
    logic [7:0]              wd;
    logic [1:0]              chan_sel;
    logic                    data_port;
    logic                    gated;
    logic [15:0]             count_word;
    logic [CounterWidth-1:0] view;
    logic [31:0]             view_wide;
    logic [CounterWidth-1:0] dec;
    logic                    terminal [2];
    logic [7:0]              rd;

    is_write = (s1_data_r.mode == itc_pkg::MODE_WRITE);
    is_read  = (s1_data_r.mode == itc_pkg::MODE_READ);
    is_tick  = (s1_data_r.mode == itc_pkg::MODE_TICK);
    wd       = s1_data_r.write_data;
    rd       = '0;

    counter_value_nxt = counter_value_r;
    reload_value_nxt  = reload_value_r;
    latched_value_nxt = latched_value_r;
    pending_low_nxt   = pending_low_r;
    periodic_mode_nxt = periodic_mode_r;
    write_phase_nxt   = write_phase_r;
    read_phase_nxt    = read_phase_r;
    latch_held_nxt    = latch_held_r;
    running_nxt       = running_r;
    output_level_nxt  = output_level_r;
    gate_bits_nxt     = gate_bits_r;

    // The gate port holds the channel 2 gate in bit 0 and the speaker bit in
    // bit 1; anything above is dropped on a write.
    if (is_write && (s1_data_r.port_sel == itc_pkg::PORT_GATE)) begin
      gate_bits_nxt = wd[1:0];
    end
    if (is_read && (s1_data_r.port_sel == itc_pkg::PORT_GATE)) begin
      rd[1:0]                   = gate_bits_r;
      rd[itc_pkg::GATE_OUT_BIT] = output_level_r[1];
    end

    for (int ch = 0; ch < 2; ch++) begin
      chan_sel    = (ch == 0) ? itc_pkg::CMD_SEL_CH0 : itc_pkg::CMD_SEL_CH2;
      data_port   = (ch == 0) ? (s1_data_r.port_sel == itc_pkg::PORT_CH0)
                              : (s1_data_r.port_sel == itc_pkg::PORT_CH2);
      gated       = (ch == 0) ? 1'b1 : gate_bits_r[0];
      count_word  = {wd, pending_low_r[ch]};
      view        = latch_held_r[ch] ? latched_value_r[ch] : counter_value_r[ch];
      view_wide   = 32'(view);
      dec         = counter_value_r[ch] - CounterWidth'(1);
      terminal[ch] = 1'b0;

      // Command byte aimed at this channel: either a counter latch or a
      // mode change. Channel 1 and read-back commands match neither channel.
      if (is_write && (s1_data_r.port_sel == itc_pkg::PORT_CMD) &&
          (wd[7:6] == chan_sel)) begin
        if (wd[5:4] == itc_pkg::CMD_ACC_LATCH) begin
          // A second latch is ignored until the first has been read out.
          if (!latch_held_r[ch]) begin
            latched_value_nxt[ch] = counter_value_r[ch];
            latch_held_nxt[ch]    = 1'b1;
            read_phase_nxt[ch]    = 1'b0;
          end
        end else begin
          periodic_mode_nxt[ch] = (wd[3:1] == itc_pkg::CMD_MODE_RATE) ||
                                  (wd[3:1] == itc_pkg::CMD_MODE_RATE_X);
          running_nxt[ch]       = 1'b0;
          write_phase_nxt[ch]   = 1'b0;
          read_phase_nxt[ch]    = 1'b0;
          latch_held_nxt[ch]    = 1'b0;
          output_level_nxt[ch]  = periodic_mode_nxt[ch];
        end
      end

      // Count bytes arrive low first. The high byte loads the counter and
      // starts it; outside modes 2 and 6 both bytes force the output low.
      if (is_write && data_port) begin
        if (!write_phase_r[ch]) begin
          pending_low_nxt[ch] = wd;
          write_phase_nxt[ch] = 1'b1;
          if (!periodic_mode_r[ch]) begin
            running_nxt[ch]      = 1'b0;
            output_level_nxt[ch] = 1'b0;
          end
        end else begin
          reload_value_nxt[ch]  = CounterWidth'(count_word);
          counter_value_nxt[ch] = CounterWidth'(count_word);
          running_nxt[ch]       = 1'b1;
          write_phase_nxt[ch]   = 1'b0;
          if (!periodic_mode_r[ch]) begin
            output_level_nxt[ch] = 1'b0;
          end
        end
      end

      // Reads return the low byte, then bits 15:8, of the latch if one is
      // held, otherwise of the live count. The second byte frees the latch.
      if (is_read && data_port) begin
        if (!read_phase_r[ch]) begin
          rd                 = view_wide[7:0];
          read_phase_nxt[ch] = 1'b1;
        end else begin
          rd                 = view_wide[15:8];
          read_phase_nxt[ch] = 1'b0;
          latch_held_nxt[ch] = 1'b0;
        end
      end

      // A tick first restores the mode 2 output after its one-item low
      // pulse, then decrements if the channel is running and gated. A count
      // of zero wraps, so a loaded zero lasts a full counter period.
      if (is_tick) begin
        if (periodic_mode_r[ch]) begin
          output_level_nxt[ch] = 1'b1;
        end
        if (running_r[ch] && gated) begin
          counter_value_nxt[ch] = dec;
          if (dec == '0) begin
            terminal[ch] = 1'b1;
            if (periodic_mode_r[ch]) begin
              counter_value_nxt[ch] = reload_value_r[ch];
              output_level_nxt[ch]  = 1'b0;
            end else begin
              output_level_nxt[ch]  = 1'b1;
            end
          end
        end
      end
    end

    out_data_nxt.read_data    = rd;
    out_data_nxt.expiry_pulse = terminal[0];
    out_data_nxt.ruler_output = output_level_nxt[1];
  end

endmodule

[rtl/itc_checker.sv]
// -----------------------------------------------------------------------------
// itc_checker
// Port-level checks of the interval timer, bound to its top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module itc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input itc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input itc_pkg::out_item_t out_data
);

  logic in_seen;

  // A result held back by the consumer must not change.
  assign in_seen = in_valid && in_ready;

  `ITC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Only a tick can give an expiry, and a tick never returns read data.
  `ITC_ASSERT(a_pulse_no_data, clk, rst_n, out_valid && out_data.expiry_pulse |-> out_data.read_data == 8'd0, "expiry with read data")

  // The input side stalls only while a result waits to be taken.
  `ITC_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output back-pressure")

  // No result straight after reset, and an accepted item passes stage one and
  // then shows as a valid result when out_ready stays high.
  `ITC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
  `ITC_ASSERT(a_latency, clk, rst_n, in_seen && out_ready ##1 out_ready |=> out_valid, "result late")

endmodule

bind interval_timer_two_channel_top itc_checker u_itc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
